/* design/plid_pkg.sv */
// Package for the positional list: request and status codes, field widths.
// No dependencies; used by positional_list_insert_delete.
package plid_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned POS_W    = 7;
   localparam int unsigned TOTAL_W  = 7;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_BADPOS = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

endpackage

/* design/positional_list_insert_delete.sv */
// Positional list top level: entry memory with one read and one write port, fill count; uses plid_pkg.
// A request that reads n = count - position + 1 entries steps through ST_SHIFT, ST_LAST and ST_COMMIT;
// errors and appends go straight to ST_COMMIT. In ST_SHIFT the memory read port moves one entry per cycle.
// One request at a time; busy stays high until the response cycle, so no new request is accepted
// before the response to the last one.
// Reset clears the fill count and control; rsp_valid is a one-cycle strobe the receiver cannot stall.
module positional_list_insert_delete #(
   parameter int unsigned LIST_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [plid_pkg::POS_W-1:0]    req_position,
   input  logic signed [plid_pkg::VALUE_W-1:0] req_new_value,
   output logic                          rsp_valid,
   output logic [plid_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [plid_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [plid_pkg::TOTAL_W-1:0]  rsp_entry_total
);
   import plid_pkg::*;

   localparam int unsigned AW = $clog2(LIST_DEPTH);
   localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_LAST,
      ST_COMMIT
   } state_type;

   state_type            state_ff;
   logic [CW-1:0]        count_ff;
   logic                 op_ff;
   logic                 ok_ff;
   status_type           status_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [AW-1:0]        ptr_ff;
   logic [AW-1:0]        end_ff;
   logic                 pend_ff;
   logic [AW-1:0]        dst_ff;
   logic                 grab_ff;
   logic [VALUE_W-1:0]   removed_ff;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [VALUE_W-1:0]   rsp_removed_ff;
   logic [TOTAL_W-1:0]   rsp_total_ff;

   logic [VALUE_W-1:0]   mem [LIST_DEPTH];
   logic [VALUE_W-1:0]   rd_data_ff;

   logic                 accept;
   logic [7:0]           pos8;
   logic [7:0]           cnt8;
   status_type           status_in;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [VALUE_W-1:0]   mem_wd;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign pos8   = {1'b0, req_position};
   assign cnt8   = 8'(count_ff);

   always_comb begin
      status_in = STATUS_OK;
      if (req_operation == OP_INSERT) begin
         if (cnt8 == 8'(LIST_DEPTH)) status_in = STATUS_FULL;
         else if (pos8 == 8'd0 || pos8 > cnt8 + 8'd1) status_in = STATUS_BADPOS;
      end else begin
         if (cnt8 == 8'd0) status_in = STATUS_EMPTY;
         else if (pos8 == 8'd0 || pos8 > cnt8) status_in = STATUS_BADPOS;
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = dst_ff;
      mem_wd = rd_data_ff;
      if (pend_ff) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_COMMIT && ok_ff && op_ff == OP_INSERT) begin
         mem_we = 1'b1;
         mem_wa = end_ff;
         mem_wd = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (state_ff == ST_SHIFT) rd_data_ff <= mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         grab_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         grab_ff      <= 1'b0;
         if (grab_ff) removed_ff <= rd_data_ff;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff      <= req_operation;
                  value_ff   <= req_new_value;
                  status_ff  <= status_in;
                  ok_ff      <= (status_in == STATUS_OK);
                  removed_ff <= '0;
                  end_ff     <= AW'(req_position - POS_W'(1));
                  if (status_in != STATUS_OK) begin
                     state_ff <= ST_COMMIT;
                  end else if (req_operation == OP_INSERT) begin
                     ptr_ff   <= AW'(count_ff - CW'(1));
                     state_ff <= (pos8 <= cnt8) ? ST_SHIFT : ST_COMMIT;
                  end else begin
                     ptr_ff   <= AW'(req_position - POS_W'(1));
                     state_ff <= ST_SHIFT;
                  end
               end
            end
            ST_SHIFT: begin
               if (op_ff == OP_INSERT) begin
                  pend_ff <= 1'b1;
                  dst_ff  <= ptr_ff + AW'(1);
                  ptr_ff  <= ptr_ff - AW'(1);
                  if (ptr_ff == end_ff) state_ff <= ST_LAST;
               end else begin
                  pend_ff <= (ptr_ff != end_ff);
                  grab_ff <= (ptr_ff == end_ff);
                  dst_ff  <= ptr_ff - AW'(1);
                  ptr_ff  <= ptr_ff + AW'(1);
                  if (CW'(ptr_ff) == count_ff - CW'(1)) state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               rsp_valid_ff   <= 1'b1;
               rsp_status_ff  <= status_ff;
               rsp_removed_ff <= removed_ff;
               if (!ok_ff) begin
                  rsp_total_ff <= TOTAL_W'(count_ff);
               end else if (op_ff == OP_INSERT) begin
                  count_ff     <= count_ff + CW'(1);
                  rsp_total_ff <= TOTAL_W'(count_ff + CW'(1));
               end else begin
                  count_ff     <= count_ff - CW'(1);
                  rsp_total_ff <= TOTAL_W'(count_ff - CW'(1));
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_total   = rsp_total_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt8 <= 8'(LIST_DEPTH))
      else $error("fill count above depth");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_ff)
      else $error("shift write pending while idle");

endmodule
